/* rtl/core/icms_pkg.sv */
// ----------------------------------------------------------------------------
// Interval clique sweep package
// Shared widths, limits and the command type passed from the sequencer to the
// sweep unit.
// ----------------------------------------------------------------------------
package icms_pkg;

    localparam int IN_TIME_W    = 16;
    localparam int MASK_W       = 32;
    localparam int IDX_W        = 5;
    localparam int RESULT_LIMIT = 32;

    typedef struct packed {
        logic go;
        logic dropped;
    } t_sweep_cmd;

endpackage

/* rtl/core/icms_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module icms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/icms_rank_cmp.sv */
// ----------------------------------------------------------------------------
// Event rank comparator
// Tells how many of the two events of one job sort before the event under
// ranking, by time, then finish time, then event code.
// ----------------------------------------------------------------------------
module icms_rank_cmp #(
    parameter int TW = 16,
    parameter int CW = 6
) (
    input  logic [TW-1:0] i_tc,
    input  logic [TW-1:0] i_fc,
    input  logic [CW-1:0] i_c,
    input  logic [TW-1:0] i_s,
    input  logic [TW-1:0] i_f,
    input  logic [CW-2:0] i_j,
    output logic [1:0]    o_cnt
);

    logic [CW-1:0] w_cs;
    logic [CW-1:0] w_ce;
    logic          w_start_lt;
    logic          w_end_lt;

    assign w_cs = {i_j, 1'b0};
    assign w_ce = {i_j, 1'b1};

    assign w_start_lt = (i_s < i_tc) ||
                        ((i_s == i_tc) && ((i_f < i_fc) ||
                                           ((i_f == i_fc) && (w_cs < i_c))));
    assign w_end_lt   = (i_f < i_tc) ||
                        ((i_f == i_tc) && ((i_f < i_fc) ||
                                           ((i_f == i_fc) && (w_ce < i_c))));

    assign o_cnt = {1'b0, w_start_lt} + {1'b0, w_end_lt};

endmodule

/* rtl/core/icms_sweep.sv */
// ----------------------------------------------------------------------------
// Clique sweep unit
// Walks the sorted event list, tracks the active job mask and delivers one
// output beat per maximal subset.
// ----------------------------------------------------------------------------
module icms_sweep import icms_pkg::*; #(
    parameter int MAX_JOBS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_sweep_cmd                          i_cmd,
    input  logic [$clog2(MAX_JOBS+1)-1:0]       i_n,
    output logic [$clog2(MAX_JOBS)+1-1:0]       o_raddr,
    input  logic [$clog2(MAX_JOBS)+1-1:0]       i_rdata,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [IDX_W-1:0]                    o_clique_index,
    output logic [MASK_W-1:0]                   o_member_mask,
    output logic                                o_overflow,
    output logic                                o_last_clique,
    output logic                                o_done
);

    localparam int JW  = $clog2(MAX_JOBS);
    localparam int CW  = JW + 1;
    localparam int CNW = $clog2(MAX_JOBS + 1);

    typedef enum logic [3:0] {
        SW_IDLE = 4'b0001,
        SW_RD   = 4'b0010,
        SW_EVAL = 4'b0100,
        SW_OUT  = 4'b1000
    } t_sw_state;

    t_sw_state         r_state, n_state;
    logic [CNW-1:0]    r_n, n_n;
    logic              r_drop, n_drop;
    logic [CNW:0]      r_i, n_i;
    logic [CNW-1:0]    r_starts, n_starts;
    logic              r_after, n_after;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [MASK_W-1:0] r_omask, n_omask;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_final, n_final;

    logic [CNW:0]      w_ne;
    logic [MASK_W-1:0] w_bit;

    assign w_ne  = {r_n, 1'b0};
    assign w_bit = {{(MASK_W-1){1'b0}}, 1'b1} << i_rdata[CW-1:1];

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_drop   = r_drop;
        n_i      = r_i;
        n_starts = r_starts;
        n_after  = r_after;
        n_mask   = r_mask;
        n_omask  = r_omask;
        n_k      = r_k;
        n_final  = r_final;
        case (r_state)
            SW_IDLE: begin
                if (i_cmd.go) begin
                    n_n      = i_n;
                    n_drop   = i_cmd.dropped;
                    n_i      = '0;
                    n_starts = '0;
                    n_after  = 1'b1;
                    n_mask   = '0;
                    n_k      = '0;
                    n_final  = 1'b0;
                    n_state  = SW_RD;
                end
            end
            SW_RD: begin
                if (r_i == w_ne) begin
                    n_omask = r_mask;
                    n_final = 1'b1;
                    n_state = SW_OUT;
                end else begin
                    n_state = SW_EVAL;
                end
            end
            SW_EVAL: begin
                n_i = r_i + 1'b1;
                if (!i_rdata[0]) begin
                    n_starts = r_starts + 1'b1;
                    n_mask   = r_mask | w_bit;
                    n_after  = 1'b1;
                    n_state  = SW_RD;
                end else if (r_starts == r_n) begin
                    n_omask = r_mask;
                    n_final = 1'b1;
                    n_state = SW_OUT;
                end else if (r_after) begin
                    n_omask = r_mask;
                    n_final = (r_k == IDX_W'(RESULT_LIMIT - 1));
                    n_after = 1'b0;
                    n_mask  = r_mask & ~w_bit;
                    n_state = SW_OUT;
                end else begin
                    n_mask  = r_mask & ~w_bit;
                    n_state = SW_RD;
                end
            end
            SW_OUT: begin
                if (i_ready) begin
                    if (r_final) begin
                        n_state = SW_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = SW_RD;
                    end
                end
            end
            default: begin
                n_state = SW_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n      <= n_n;
        r_drop   <= n_drop;
        r_i      <= n_i;
        r_starts <= n_starts;
        r_after  <= n_after;
        r_mask   <= n_mask;
        r_omask  <= n_omask;
        r_k      <= n_k;
        r_final  <= n_final;
    end

    assign o_raddr        = r_i[CW-1:0];
    assign o_valid        = (r_state == SW_OUT);
    assign o_clique_index = r_k;
    assign o_member_mask  = r_omask;
    assign o_overflow     = r_drop;
    assign o_last_clique  = r_final;
    assign o_done         = (r_state == SW_OUT) && i_ready && r_final;

endmodule

/* rtl/core/interval_max_clique_sweep_top.sv */
// ----------------------------------------------------------------------------
// Interval maximal clique sweep
// Jobs arrive one beat each on the input channel as start and finish times.
// The beat with i_last set closes the set. Each job's two events are ranked
// by counting, for every event, the events that sort before it; one shared
// comparator pair checks both events of one job per cycle against the event
// being ranked. The ranked list is then swept, each event read and then
// evaluated in turn, and each maximal subset leaves on the output channel as
// one beat, the last one marked by o_last_clique.
// While jobs load, one beat is taken per cycle. From the closing beat until
// the final result beat is taken, the input is not ready. A stalled receiver
// holds the sweep; the result beat stays unchanged until it is taken.
// Reset clears the job count, the overflow flag and both sequencers; the
// job and event memories are left as they are and are rewritten every set.
// Jobs beyond MAX_JOBS are dropped and flagged on every result of the set.
// ----------------------------------------------------------------------------
module interval_max_clique_sweep_top import icms_pkg::*; #(
    parameter int MAX_JOBS  = 32,
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TIME_W-1:0]  i_job_start,
    input  logic [IN_TIME_W-1:0]  i_job_finish,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_W-1:0]      o_clique_index,
    output logic [MASK_W-1:0]     o_member_mask,
    output logic                  o_overflow,
    output logic                  o_last_clique
);

    localparam int JW  = $clog2(MAX_JOBS);
    localparam int CW  = JW + 1;
    localparam int CNW = $clog2(MAX_JOBS + 1);

    typedef enum logic [4:0] {
        S_LOAD   = 5'b00001,
        S_KEYRD  = 5'b00010,
        S_KEYLAT = 5'b00100,
        S_SCAN   = 5'b01000,
        S_SWEEP  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNW-1:0]   r_count, n_count;
    logic             r_dropped, n_dropped;
    logic [CNW-1:0]   r_n, n_n;
    logic             r_drop_set, n_drop_set;
    logic [CW-1:0]    r_c, n_c;
    logic [CW-1:0]    r_ne_m1, n_ne_m1;
    logic [TIME_BITS-1:0] r_tc, n_tc;
    logic [TIME_BITS-1:0] r_fc, n_fc;
    logic [CNW-1:0]   r_j, n_j;
    logic             r_pv, n_pv;
    logic [JW-1:0]    r_pj, n_pj;
    logic [CW-1:0]    r_rank, n_rank;

    logic             w_accept;
    logic             w_fits;
    logic             w_store_we;
    logic [CNW-1:0]   w_after;
    logic [CNW-1:0]   w_nm1;
    logic [JW-1:0]    w_st_raddr;
    logic [TIME_BITS-1:0] w_rd_s;
    logic [TIME_BITS-1:0] w_rd_f;
    logic [1:0]       w_cnt;
    logic             w_scan_done;
    logic [CW-1:0]    w_ev_raddr;
    logic [CW-1:0]    w_ev_rdata;
    t_sweep_cmd       w_cmd;
    logic             w_sw_done;

    assign o_ready     = (r_state == S_LOAD);
    assign w_accept    = i_valid && o_ready;
    assign w_fits      = (r_count < CNW'(MAX_JOBS));
    assign w_store_we  = w_accept && w_fits;
    assign w_after     = w_fits ? (r_count + 1'b1) : r_count;
    assign w_nm1       = w_after - 1'b1;
    assign w_st_raddr  = (r_state == S_KEYRD) ? r_c[CW-1:1] : r_j[JW-1:0];
    assign w_scan_done = (r_state == S_SCAN) && (r_j == r_n) && !r_pv;

    assign w_cmd.go      = w_scan_done && (r_c == r_ne_m1);
    assign w_cmd.dropped = r_drop_set;

    icms_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_JOBS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_count[JW-1:0]),
        .i_wdata (TIME_BITS'(i_job_start)),
        .i_raddr (w_st_raddr),
        .o_rdata (w_rd_s)
    );

    icms_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_JOBS)
    ) u_finish_ram (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_count[JW-1:0]),
        .i_wdata (TIME_BITS'(i_job_finish)),
        .i_raddr (w_st_raddr),
        .o_rdata (w_rd_f)
    );

    icms_ram #(
        .WIDTH (CW),
        .DEPTH (2 * MAX_JOBS)
    ) u_event_ram (
        .i_clk   (i_clk),
        .i_we    (w_scan_done),
        .i_waddr (r_rank),
        .i_wdata (r_c),
        .i_raddr (w_ev_raddr),
        .o_rdata (w_ev_rdata)
    );

    icms_rank_cmp #(
        .TW (TIME_BITS),
        .CW (CW)
    ) u_rank_cmp (
        .i_tc  (r_tc),
        .i_fc  (r_fc),
        .i_c   (r_c),
        .i_s   (w_rd_s),
        .i_f   (w_rd_f),
        .i_j   (r_pj),
        .o_cnt (w_cnt)
    );

    icms_sweep #(
        .MAX_JOBS (MAX_JOBS)
    ) u_sweep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_n            (r_n),
        .o_raddr        (w_ev_raddr),
        .i_rdata        (w_ev_rdata),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_clique_index (o_clique_index),
        .o_member_mask  (o_member_mask),
        .o_overflow     (o_overflow),
        .o_last_clique  (o_last_clique),
        .o_done         (w_sw_done)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_n        = r_n;
        n_drop_set = r_drop_set;
        n_c        = r_c;
        n_ne_m1    = r_ne_m1;
        n_tc       = r_tc;
        n_fc       = r_fc;
        n_j        = r_j;
        n_pv       = r_pv;
        n_pj       = r_pj;
        n_rank     = r_rank;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (i_last) begin
                        n_n        = w_after;
                        n_ne_m1    = {w_nm1[JW-1:0], 1'b1};
                        n_drop_set = r_dropped || !w_fits;
                        n_count    = '0;
                        n_dropped  = 1'b0;
                        n_c        = '0;
                        n_state    = S_KEYRD;
                    end else begin
                        n_count   = w_after;
                        n_dropped = r_dropped || !w_fits;
                    end
                end
            end
            S_KEYRD: begin
                n_state = S_KEYLAT;
            end
            S_KEYLAT: begin
                n_tc    = r_c[0] ? w_rd_f : w_rd_s;
                n_fc    = w_rd_f;
                n_j     = '0;
                n_pv    = 1'b0;
                n_rank  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_pv) begin
                    n_rank = r_rank + CW'(w_cnt);
                end
                if (r_j != r_n) begin
                    n_pj = r_j[JW-1:0];
                    n_pv = 1'b1;
                    n_j  = r_j + 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (w_scan_done) begin
                    n_c     = r_c + 1'b1;
                    n_state = (r_c == r_ne_m1) ? S_SWEEP : S_KEYRD;
                end
            end
            S_SWEEP: begin
                if (w_sw_done) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
        r_n        <= n_n;
        r_drop_set <= n_drop_set;
        r_c        <= n_c;
        r_ne_m1    <= n_ne_m1;
        r_tc       <= n_tc;
        r_fc       <= n_fc;
        r_j        <= n_j;
        r_pv       <= n_pv;
        r_pj       <= n_pj;
        r_rank     <= n_rank;
    end

endmodule
